// ===== rtl/spqd_pkg.sv =====
// Package for the stable priority queue with guarded discharge.
// Holds the entry and cell control types, status and operation codes, and priority bounds.
// No dependencies; every other file of the block imports it.
`default_nettype none

package spqd_pkg;

	localparam int PRIO_W = 5;
	localparam int TAG_W  = 16;
	localparam int STAT_W = 3;
	localparam int OCC_W  = 5;

	// Operation codes carried in the kind field.
	localparam logic KIND_INSERT    = 1'b0;
	localparam logic KIND_DISCHARGE = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STAT_W-1:0] ST_POPPED    = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
	localparam logic [STAT_W-1:0] ST_TREATMENT = 3'd4;
	localparam logic [STAT_W-1:0] ST_INVALID   = 3'd5;

	// Finished entries carry -1 or 0; entries in treatment lie in 1 up to (not including) 11.
	localparam logic signed [PRIO_W-1:0] PRIO_DONE_LO  = -5'sd1;
	localparam logic signed [PRIO_W-1:0] PRIO_DONE_HI  = 5'sd0;
	localparam logic signed [PRIO_W-1:0] PRIO_TREAT_LO = 5'sd1;
	localparam logic signed [PRIO_W-1:0] PRIO_TREAT_END = 5'sd11;

	typedef struct packed {
		logic signed [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]         tag;
	} entry_t;

	// Per-cycle command broadcast to every cell of the row.
	typedef struct packed {
		logic   ins;
		logic   pop;
		entry_t new_entry;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/spqd_if.sv =====
// Valid/ready channel interfaces of the stable priority queue.
// Depends on spqd_pkg for field widths.
`default_nettype none

interface spqd_in_if
	import spqd_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic signed [PRIO_W-1:0] priority_req;
	logic [TAG_W-1:0]         tag;

	modport source (output valid, output kind, output priority_req, output tag, input ready);
	modport sink   (input valid, input kind, input priority_req, input tag, output ready);
endinterface

interface spqd_out_if
	import spqd_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic [TAG_W-1:0]         out_tag;
	logic signed [PRIO_W-1:0] out_priority;
	logic [OCC_W-1:0]         occupancy;

	modport source (output valid, output status, output out_tag, output out_priority,
		output occupancy, input ready);
	modport sink   (input valid, input status, input out_tag, input out_priority,
		input occupancy, output ready);
endinterface

`default_nettype wire

// ===== rtl/stable_priority_queue_discharge.sv =====
// Top level of the stable sorted priority queue with guarded discharge.
// Depends on spqd_pkg, the interfaces in spqd_if.sv and the slot cell spqd_cell.
`default_nettype none

// Channel   Direction  Transaction carries
// in_ch     sink       kind, priority_req, tag
// out_ch    source     status, out_tag, out_priority, occupancy
//
// Every transaction on in_ch produces exactly one result
// transaction on out_ch, registered in the output stage. The row of DEPTH
// cells updates in the same cycle as that register, so a new transaction can follow on every
// cycle while the result register drains. in_ch is stalled only while a result
// is held and out_ch is not ready. Reset clears the entry count and the output
// valid flag; the cell contents are left as they are and never read before written.

module stable_priority_queue_discharge
	import spqd_pkg::*;
#(
	parameter int DEPTH = 16
)(
	input  wire logic clk,
	input  wire logic arst_n,
	spqd_in_if.sink   in_ch,
	spqd_out_if.source out_ch
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;

	entry_t     cell_entry [DEPTH];
	logic       cell_keep  [DEPTH];
	logic       cell_occ   [DEPTH];
	cell_ctrl_t ctrl;

	logic   accept;
	logic   is_insert;
	logic   full;
	logic   empty;
	logic   head_done;
	logic   head_treat;
	entry_t head;

	logic                     out_valid_q;
	logic [STAT_W-1:0]        status_q;
	logic [TAG_W-1:0]         tag_q;
	logic signed [PRIO_W-1:0] prio_q;
	logic [OCC_W-1:0]         occ_q;

	logic [STAT_W-1:0]        status_d;
	logic [TAG_W-1:0]         tag_d;
	logic signed [PRIO_W-1:0] prio_d;

	// The input may be taken whenever the result register is free or is being emptied.
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_insert   = (in_ch.kind == KIND_INSERT);

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = cell_entry[0];

	// Only the head decides a discharge: finished entries leave, others block the queue.
	assign head_done  = (head.prio == PRIO_DONE_LO) || (head.prio == PRIO_DONE_HI);
	assign head_treat = (head.prio >= PRIO_TREAT_LO) && (head.prio < PRIO_TREAT_END);

	assign ctrl.ins       = accept && is_insert && !full;
	assign ctrl.pop       = accept && !is_insert && !empty && head_done;
	assign ctrl.new_entry = '{prio: in_ch.priority_req, tag: in_ch.tag};

	always_comb begin
		count_d = count_q;
		if (ctrl.ins) begin
			count_d = count_q + CW'(1);
		end else if (ctrl.pop) begin
			count_d = count_q - CW'(1);
		end
	end

	always_comb begin
		status_d = ST_INSERTED;
		tag_d    = '0;
		prio_d   = '0;
		if (is_insert) begin
			status_d = full ? ST_FULL : ST_INSERTED;
		end else if (empty) begin
			status_d = ST_EMPTY;
		end else begin
			tag_d  = head.tag;
			prio_d = head.prio;
			priority if (head_done) begin
				status_d = ST_POPPED;
			end else if (head_treat) begin
				status_d = ST_TREATMENT;
			end else begin
				status_d = ST_INVALID;
			end
		end
	end

	// The row of cells: an insert opens a gap after all entries of equal or lower
	// priority and shifts the rest one slot toward the tail; a pop shifts all toward the head.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_entry;
		logic   left_keep;
		entry_t right_entry;

		assign cell_occ[i] = (count_q > CW'(i));

		if (i == 0) begin : g_first
			assign left_entry = cell_entry[0];
			assign left_keep  = 1'b1;
		end else begin : g_mid
			assign left_entry = cell_entry[i-1];
			assign left_keep  = cell_keep[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_entry = cell_entry[i];
		end else begin : g_inner
			assign right_entry = cell_entry[i+1];
		end

		spqd_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (cell_occ[i]),
			.left_entry  (left_entry),
			.left_keep   (left_keep),
			.right_entry (right_entry),
			.entry       (cell_entry[i]),
			.keep        (cell_keep[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			tag_q    <= tag_d;
			prio_q   <= prio_d;
			occ_q    <= OCC_W'(count_d);
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.status       = status_q;
	assign out_ch.out_tag      = tag_q;
	assign out_ch.out_priority = prio_q;
	assign out_ch.occupancy    = occ_q;

endmodule

`default_nettype wire

// ===== rtl/spqd_cell.sv =====
// One slot of the sorted queue row: holds an entry and shifts with its neighbors.
// Depends on spqd_pkg for entry_t and cell_ctrl_t.
`default_nettype none

module spqd_cell
	import spqd_pkg::*;
(
	input  wire logic       clk,
	input  wire cell_ctrl_t ctrl,
	input  wire logic       occupied,
	input  wire entry_t     left_entry,
	input  wire logic       left_keep,
	input  wire entry_t     right_entry,
	output entry_t          entry,
	output logic            keep
);

	entry_t entry_q;

	// An occupied slot whose priority is not above the new one stays put on an insert.
	assign keep  = occupied && (entry_q.prio <= ctrl.new_entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		priority if (ctrl.ins) begin
			priority if (keep) begin
				entry_q <= entry_q;
			end else if (left_keep) begin
				entry_q <= ctrl.new_entry;
			end else begin
				entry_q <= left_entry;
			end
		end else if (ctrl.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

`default_nettype wire

// ===== tb/spqd_queue_checker.sv =====
// Result checker for the stable priority queue with guarded discharge.
// Keeps a sorted copy of the queue, predicts each result and compares it field by field.
// Depends on spqd_pkg and the channel interfaces in rtl/spqd_if.sv.
module spqd_queue_checker
	import spqd_pkg::*;
#(
	parameter int DEPTH = 16
)(
	input  wire logic           clk,
	input  wire logic           arst_n,
	spqd_in_if                  in_ch,
	spqd_out_if                 out_ch,
	output int                  failures,
	output int                  pending,
	output int                  results_checked,
	output int                  peak_occupancy,
	output logic [ST_INVALID:0] status_seen
);

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic [TAG_W-1:0]         tag;
		logic signed [PRIO_W-1:0] prio;
		logic [OCC_W-1:0]         occupancy;
	} outcome_t;

	// Held entries, head first, in ascending priority and arrival order.
	entry_t   held[$];
	// Outcomes of accepted requests whose result transaction has not come yet.
	outcome_t due[$];

	// Applies one request to the held entries and returns the outcome it must produce.
	function automatic outcome_t serve_request(input logic kind,
		input logic signed [PRIO_W-1:0] prio, input logic [TAG_W-1:0] tag);
		outcome_t res;
		entry_t   head;
		entry_t   fresh;
		int       pos;
		res = '0;
		if (kind == KIND_INSERT) begin
			if (held.size() >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				// A new entry goes behind every entry of lower or equal priority.
				pos = 0;
				while (pos < held.size() && $signed(held[pos].prio) <= prio)
					pos++;
				fresh.prio = prio;
				fresh.tag  = tag;
				held.insert(pos, fresh);
				res.status = ST_INSERTED;
			end
		end else if (held.size() == 0) begin
			res.status = ST_EMPTY;
		end else begin
			head     = held[0];
			res.tag  = head.tag;
			res.prio = head.prio;
			if (head.prio == PRIO_DONE_LO || head.prio == PRIO_DONE_HI) begin
				held.delete(0);
				res.status = ST_POPPED;
			end else if ($signed(head.prio) >= PRIO_TREAT_LO &&
				$signed(head.prio) < PRIO_TREAT_END) begin
				res.status = ST_TREATMENT;
			end else begin
				res.status = ST_INVALID;
			end
		end
		res.occupancy = OCC_W'(held.size());
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			held.delete();
			due.delete();
			pending         = 0;
			failures        = 0;
			results_checked = 0;
			peak_occupancy  = 0;
			status_seen     = '0;
		end else begin
			// The request is predicted first so that a result in the same cycle still finds
			// the oldest outstanding outcome at the front.
			if (in_ch.valid && in_ch.ready)
				due.push_back(serve_request(in_ch.kind, in_ch.priority_req, in_ch.tag));
			if (out_ch.valid && out_ch.ready) begin
				results_checked++;
				if (out_ch.status <= ST_INVALID)
					status_seen[out_ch.status] = 1'b1;
				if (int'(out_ch.occupancy) > peak_occupancy)
					peak_occupancy = int'(out_ch.occupancy);
				if (due.size() == 0) begin
					$error("result transaction with no request outstanding: status %0d",
						out_ch.status);
					failures++;
				end else begin
					want = due.pop_front();
					if (out_ch.status !== want.status) begin
						$error("status mismatch: expected %0d, got %0d",
							want.status, out_ch.status);
						failures++;
					end
					if (out_ch.out_tag !== want.tag) begin
						$error("out_tag mismatch: expected 0x%04h, got 0x%04h",
							want.tag, out_ch.out_tag);
						failures++;
					end
					if (out_ch.out_priority !== want.prio) begin
						$error("out_priority mismatch: expected %0d, got %0d",
							$signed(want.prio), out_ch.out_priority);
						failures++;
					end
					if (out_ch.occupancy !== want.occupancy) begin
						$error("occupancy mismatch: expected %0d, got %0d",
							want.occupancy, out_ch.occupancy);
						failures++;
					end
				end
			end
			pending = due.size();
		end
	end

endmodule

// ===== tb/stable_priority_queue_discharge_tb.sv =====
// Testbench top for the stable priority queue with guarded discharge.
// Drives request transactions and a stalling result receiver; the checker predicts results.
// Depends on spqd_pkg, rtl/spqd_if.sv, the block and tb/spqd_queue_checker.sv.
module stable_priority_queue_discharge_tb;
	import spqd_pkg::*;

	localparam int DEPTH = 16;
	// The random part stops once this many requests in total have been driven.
	localparam int MAIN_END = 690;
	// Entries of treatment priority never leave the queue, since only the head is ever
	// popped and only when it is finished. Their number is capped so that at least six slots
	// of the queue stay free for entries that can be popped again.
	localparam int MAX_TREAT_INSERTS = 10;
	// Length of the one long stall of the receiver, in cycles.
	localparam int LONG_HOLD = 80;
	// The limit lies well above the slowest correct stretch without any transaction,
	// which is the long stall plus the longest sender gap.
	localparam int STALL_LIMIT = 2000;
	// The result is registered, so it shows in the cycle after its request is accepted;
	// spare cycles after the drain let any stray result show up before the verdict.
	localparam int DRAIN_CYCLES = 8;

	logic clk;
	logic arst_n;

	spqd_in_if  in_ch();
	spqd_out_if out_ch();

	int                  failures;
	int                  pending;
	int                  results_checked;
	int                  peak_occupancy;
	logic [ST_INVALID:0] status_seen;

	int sent_inserts;
	int sent_discharges;
	int treat_inserts;
	int quiet_cycles;
	int hold_requests;
	int holds_served;
	bit no_gaps;

	stable_priority_queue_discharge #(
		.DEPTH(DEPTH)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	spqd_queue_checker #(
		.DEPTH(DEPTH)
	) queue_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_ch           (in_ch),
		.out_ch          (out_ch),
		.failures        (failures),
		.pending         (pending),
		.results_checked (results_checked),
		.peak_occupancy  (peak_occupancy),
		.status_seen     (status_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle length shared by both sides: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Offers one request transaction and returns at the clock edge that accepts it. Valid
	// stays high when the next request follows at once, so it is never lowered and raised
	// in the same time step.
	task automatic send_item(input logic kind, input logic signed [PRIO_W-1:0] prio,
		input logic [TAG_W-1:0] tag);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.kind         <= kind;
		in_ch.priority_req <= prio;
		in_ch.tag          <= tag;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		if (kind == KIND_INSERT)
			sent_inserts++;
		else
			sent_discharges++;
	endtask

	// A finished entry, priority -1 or 0, is the only kind a discharge can pop.
	task automatic insert_finished();
		send_item(KIND_INSERT, $urandom_range(1) ? PRIO_DONE_LO : PRIO_DONE_HI,
			TAG_W'($urandom));
	endtask

	task automatic insert_in_treatment();
		treat_inserts++;
		send_item(KIND_INSERT, PRIO_W'($urandom_range(1, 10)), TAG_W'($urandom));
	endtask

	// The operand fields of a discharge are ignored by the block, so they carry noise.
	task automatic discharge();
		send_item(KIND_DISCHARGE, PRIO_W'($urandom), TAG_W'($urandom));
	endtask

	// Lowers valid and waits until every outstanding result has been received. The
	// first edge keeps the lowering apart from any raise in the next request.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Result receiver: runs of ready separated by random stalls, with an occasional long
	// run without any stall. When the sender asks for it, ready stays low for a long
	// stretch, so the output register fills and the block holds off new requests.
	initial begin
		int run;
		int gap;
		out_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (holds_served < hold_requests) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				holds_served++;
			end
			out_ch.ready <= 1'b1;
			run = ($urandom_range(9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
			repeat (run) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Watchdog: a long stretch with no transaction on either channel means the block hung.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Stimulus and verdict.
	initial begin
		int pick;
		int n;
		arst_n             <= 1'b0;
		in_ch.valid        <= 1'b0;
		in_ch.kind         <= KIND_INSERT;
		in_ch.priority_req <= '0;
		in_ch.tag          <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A discharge on the empty queue comes first; then one entry in
		// treatment arrives, followed by finished entries -1, 0 and -1. The discharges must pop
		// them in order -1, -1, 0 with the two -1 entries in arrival order, and then stop
		// at the head in treatment without removing it.
		discharge();
		send_item(KIND_INSERT, 5'sd5, 16'hA5A5);
		send_item(KIND_INSERT, PRIO_DONE_LO, 16'h0001);
		send_item(KIND_INSERT, PRIO_DONE_HI, 16'h0002);
		send_item(KIND_INSERT, PRIO_DONE_LO, 16'h0003);
		repeat (4) discharge();
		// Both ends of the treatment range, with the largest and the smallest tag.
		send_item(KIND_INSERT, 5'sd10, 16'hFFFF);
		send_item(KIND_INSERT, PRIO_TREAT_LO, 16'h0000);
		discharge();
		treat_inserts = 3;
		wait_drained();

		// Random part. The commonest sequences fill the queue with finished entries and discharge
		// them again, at times past the last free slot so that inserts get dropped. Mixed
		// sequences interleave both operations and now and then add an entry in treatment.
		// Short bursts of discharges reach the treatment head once the finished entries
		// are gone, and sometimes the sender stops until every result is in.
		while (sent_inserts + sent_discharges < MAIN_END) begin
			no_gaps = ($urandom_range(4) == 0);
			if (hold_requests == 0 && sent_inserts + sent_discharges >= 150)
				hold_requests++;
			pick = $urandom_range(99);
			if (pick < 45) begin
				n = $urandom_range(1, 14);
				repeat (n) insert_finished();
				repeat (n + $urandom_range(0, 3)) discharge();
			end else if (pick < 85) begin
				repeat ($urandom_range(5, 20)) begin
					if ($urandom_range(1) == 1)
						discharge();
					else if (treat_inserts < MAX_TREAT_INSERTS && $urandom_range(19) == 0)
						insert_in_treatment();
					else
						insert_finished();
				end
			end else if (pick < 95) begin
				repeat ($urandom_range(1, 5)) discharge();
			end else begin
				wait_drained();
			end
		end
		no_gaps = 1'b0;

		// Closing part. All finished entries are discharged, which leaves at most the
		// capped number of treatment entries. Then priorities outside the served range go
		// in: 11 and 15 sort behind everything, -2 and -16 take the head and block every
		// further pop for good, which is why they come last.
		wait_drained();
		repeat (DEPTH + 4) discharge();
		send_item(KIND_INSERT, 5'sd15, TAG_W'($urandom));
		send_item(KIND_INSERT, PRIO_TREAT_END, TAG_W'($urandom));
		discharge();
		send_item(KIND_INSERT, -5'sd2, TAG_W'($urandom));
		discharge();
		send_item(KIND_INSERT, 5'b10000, TAG_W'($urandom));
		discharge();
		// Fully random requests over the whole priority range follow; their inserts can fill the queue to the top.
		repeat (30) begin
			send_item($urandom_range(1) ? KIND_DISCHARGE : KIND_INSERT, PRIO_W'($urandom),
				TAG_W'($urandom));
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Drove %0d requests (%0d inserts, %0d discharges), checked %0d results.",
			sent_inserts + sent_discharges, sent_inserts, sent_discharges, results_checked);
		$display("Status codes seen, one bit per code: %b; fullest queue: %0d entries.",
			status_seen, peak_occupancy);
		if (failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches found", failures);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
